[hdl/mck_pkg.sv]
// shared types, constants and the code table of the morse character keyer
// no dependencies; used by the channel interfaces and the top level
package mck_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned UnitWidth  = 4;
   localparam int unsigned SymMax     = 5;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned IdxWidth   = 6;

   localparam logic [UnitWidth-1:0] DASH_UNITS = 4'd3;
   localparam logic [UnitWidth-1:0] DOT_UNITS  = 4'd1;
   localparam logic [UnitWidth-1:0] GAP_UNITS  = 4'd1;

   // csr register indexes
   localparam logic CSR_CHAR_GAP = 1'b0;
   localparam logic CSR_WORD_GAP = 1'b1;

   localparam logic [CharWidth-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CharWidth-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [CharWidth-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CharWidth-1:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [CharWidth-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CharWidth-1:0] ASCII_NINE    = 8'h39;
   localparam logic [CharWidth-1:0] ASCII_SPACE   = 8'h20;
   localparam logic [CharWidth-1:0] CASE_OFFSET   = 8'd32;
   localparam logic [IdxWidth-1:0]  DIGIT_BASE    = 6'd26;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SPACE,
      ST_WORD,
      ST_CHAR
   } keyer_state_type;

   typedef struct packed {
      logic [CountWidth-1:0] len;
      logic [SymMax-1:0]     pat;
   } code_entry_type;

   // pattern left aligned: first symbol in the msb, 1 is a dash
   function automatic code_entry_type code_lookup(input logic [IdxWidth-1:0] idx);
      code_entry_type e;
      unique case (idx)
         6'd0:  e = '{3'd2, 5'b01000};
         6'd1:  e = '{3'd4, 5'b10000};
         6'd2:  e = '{3'd4, 5'b10100};
         6'd3:  e = '{3'd3, 5'b10000};
         6'd4:  e = '{3'd1, 5'b00000};
         6'd5:  e = '{3'd4, 5'b00100};
         6'd6:  e = '{3'd3, 5'b11000};
         6'd7:  e = '{3'd4, 5'b00000};
         6'd8:  e = '{3'd2, 5'b00000};
         6'd9:  e = '{3'd4, 5'b01110};
         6'd10: e = '{3'd3, 5'b10100};
         6'd11: e = '{3'd4, 5'b01000};
         6'd12: e = '{3'd2, 5'b11000};
         6'd13: e = '{3'd2, 5'b10000};
         6'd14: e = '{3'd3, 5'b11100};
         6'd15: e = '{3'd4, 5'b01100};
         6'd16: e = '{3'd4, 5'b11010};
         6'd17: e = '{3'd3, 5'b01000};
         6'd18: e = '{3'd3, 5'b00000};
         6'd19: e = '{3'd1, 5'b10000};
         6'd20: e = '{3'd3, 5'b00100};
         6'd21: e = '{3'd4, 5'b00010};
         6'd22: e = '{3'd3, 5'b01100};
         6'd23: e = '{3'd4, 5'b10010};
         6'd24: e = '{3'd4, 5'b10110};
         6'd25: e = '{3'd4, 5'b11000};
         6'd26: e = '{3'd5, 5'b11111};
         6'd27: e = '{3'd5, 5'b01111};
         6'd28: e = '{3'd5, 5'b00111};
         6'd29: e = '{3'd5, 5'b00011};
         6'd30: e = '{3'd5, 5'b00001};
         6'd31: e = '{3'd5, 5'b00000};
         6'd32: e = '{3'd5, 5'b10000};
         6'd33: e = '{3'd5, 5'b11000};
         6'd34: e = '{3'd5, 5'b11100};
         6'd35: e = '{3'd5, 5'b11110};
         default: e = '{3'd1, 5'b00000};
      endcase
      return e;
   endfunction

endpackage

[hdl/mck_req_if.sv]
// character request channel of the morse keyer
// depends on mck_pkg
interface mck_req_if import mck_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] ascii_char;

   modport source (output valid, output ascii_char, input ready);
   modport sink   (input valid, input ascii_char, output ready);
endinterface

[hdl/mck_rsp_if.sv]
// led interval response channel of the morse keyer
// depends on mck_pkg
interface mck_rsp_if import mck_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 led_on;
   logic [UnitWidth-1:0] duration_units;
   logic                 last;

   modport source (output valid, output led_on, output duration_units, output last,
                   input ready);
   modport sink   (input valid, input led_on, input duration_units, input last,
                   output ready);
endinterface

[hdl/morse_character_keyer_unit.sv]
// morse character keyer: turns one ascii character into a run of led intervals
// depends on mck_pkg, mck_req_if and mck_rsp_if
//
//   channel    dir   payload                              transfer when
//   req_chan   in    ascii_char                           valid & ready
//   rsp_chan   out   led_on, duration_units, last         valid & ready
//   csr_*      in    csr_index, csr_wr_data               csr_wr_en
//
// one interval per cycle from a small sequencer stepping a pattern shift register, while rsp is not stalled
// a character is taken while the sequencer is idle and then gives 1 to 11 intervals
// req ready is high only while the sequencer is idle; the last interval may still
// sit in the output register when the next character is taken
// a stalled rsp holds the sequencer; synchronous reset restores gaps 2 and 4
module morse_character_keyer_unit import mck_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mck_req_if.sink              req_chan,
   mck_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [UnitWidth-1:0] csr_wr_data
);

   keyer_state_type       state_ff, state_in;
   logic [SymMax-1:0]     pat_ff, pat_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [UnitWidth-1:0]  char_gap_ff, word_gap_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  led_on_ff;
   logic [UnitWidth-1:0]  dur_ff;
   logic                  last_ff;

   logic                  req_xfer;
   logic                  load;
   logic [CharWidth-1:0]  folded;
   logic                  is_letter, is_digit, is_space;
   logic [IdxWidth-1:0]   idx;
   code_entry_type        entry;
   logic                  emit_led;
   logic [UnitWidth-1:0]  emit_dur;
   logic                  emit_last;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   // a new interval goes out when the output slot is free or being drained
   assign load           = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      folded = req_chan.ascii_char;
      if (req_chan.ascii_char >= ASCII_UPPER_A && req_chan.ascii_char <= ASCII_UPPER_Z) begin
         folded = req_chan.ascii_char + CASE_OFFSET;
      end
      is_letter = (folded >= ASCII_LOWER_A) && (folded <= ASCII_LOWER_Z);
      is_digit  = (folded >= ASCII_ZERO) && (folded <= ASCII_NINE);
      is_space  = (folded == ASCII_SPACE);
      if (is_letter) begin
         idx = IdxWidth'(folded - ASCII_LOWER_A);
      end else begin
         idx = IdxWidth'(folded - ASCII_ZERO) + DIGIT_BASE;
      end
      entry = code_lookup(idx);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pat_in   = pat_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pat_in = entry.pat;
               cnt_in = entry.len;
               priority if (is_letter || is_digit) state_in = ST_MARK;
               else if (is_space)                  state_in = ST_WORD;
               else                                state_in = ST_CHAR;
            end
         end
         ST_MARK: begin
            if (load) state_in = ST_SPACE;
         end
         ST_SPACE: begin
            if (load) begin
               pat_in   = {pat_ff[SymMax-2:0], 1'b0};
               cnt_in   = cnt_ff - 1'b1;
               state_in = (cnt_ff == CountWidth'(1)) ? ST_CHAR : ST_MARK;
            end
         end
         ST_WORD: begin
            if (load) state_in = ST_CHAR;
         end
         ST_CHAR: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // interval produced in each state
   always_comb begin
      emit_led  = 1'b0;
      emit_dur  = GAP_UNITS;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_MARK: begin
            emit_led = 1'b1;
            emit_dur = pat_ff[SymMax-1] ? DASH_UNITS : DOT_UNITS;
         end
         ST_SPACE: emit_dur = GAP_UNITS;
         ST_WORD:  emit_dur = word_gap_ff;
         ST_CHAR: begin
            emit_dur  = char_gap_ff;
            emit_last = 1'b1;
         end
         default: emit_dur = GAP_UNITS;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         char_gap_ff  <= 4'd2;
         word_gap_ff  <= 4'd4;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CHAR_GAP: char_gap_ff <= csr_wr_data;
               CSR_WORD_GAP: word_gap_ff <= csr_wr_data;
               default:      char_gap_ff <= char_gap_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      cnt_ff <= cnt_in;
      if (load) begin
         led_on_ff <= emit_led;
         dur_ff    <= emit_dur;
         last_ff   <= emit_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.led_on         = led_on_ff;
   assign rsp_chan.duration_units = dur_ff;
   assign rsp_chan.last           = last_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("keyer still ready after taking a character");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK || state_ff == ST_SPACE) |-> cnt_ff != '0)
      else $error("symbol count empty while sending symbols");

   a_char_gap_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR && load) |=> (state_ff == ST_IDLE) && rsp_chan.valid
         && rsp_chan.last && !rsp_chan.led_on)
      else $error("character gap did not close the character");

   a_mark_lit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK && load) |=> rsp_chan.valid && rsp_chan.led_on
         && !rsp_chan.last)
      else $error("symbol interval not lit");

endmodule

[tb/morse_character_keyer_unit_tb.sv]
// self-checking testbench for morse_character_keyer_unit: directed table, then random characters
// checked against a behavioral keyer; depends on mck_pkg, mck_req_if, mck_rsp_if and the rtl
module morse_character_keyer_unit_tb import mck_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                 led_on;
      logic [UnitWidth-1:0] duration_units;
      logic                 last;
   } interval_type;

   typedef struct {
      logic [CharWidth-1:0] ch;
      int                   n_typed;
      interval_type         typed [3];
   } stim_row_type;

   localparam interval_type DOT_ON   = '{1'b1, 4'd1, 1'b0};
   localparam interval_type DASH_ON  = '{1'b1, 4'd3, 1'b0};
   localparam interval_type SYM_OFF  = '{1'b0, 4'd1, 1'b0};
   localparam interval_type CGAP_RST = '{1'b0, 4'd2, 1'b1};
   localparam interval_type WGAP_RST = '{1'b0, 4'd4, 1'b0};
   localparam interval_type NO_IV    = '{1'b0, 4'd0, 1'b0};

   localparam int NUM_ROWS       = 22;
   localparam int NUM_PHASES     = 6;
   localparam int CHARS_PER_PHASE = 35;
   localparam int SETTLE_CYCLES  = 13;

   // typed rows hold at the reset gaps (char 2, word 4); n_typed 0 uses the keyer model
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{8'h00, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'hFF, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h20, 2, '{WGAP_RST, CGAP_RST, NO_IV}},
      '{8'h65, 3, '{DOT_ON, SYM_OFF, CGAP_RST}},
      '{8'h54, 3, '{DASH_ON, SYM_OFF, CGAP_RST}},
      '{8'h40, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h41, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h5A, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h5B, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h60, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h61, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h7A, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h7B, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h2F, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h30, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h39, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h3A, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h35, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h7F, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h80, 1, '{CGAP_RST, NO_IV, NO_IV}},
      '{8'h51, 0, '{NO_IV, NO_IV, NO_IV}},
      '{8'h79, 0, '{NO_IV, NO_IV, NO_IV}}
   };

   // patterns for a..z, then 0..9
   string morse_pat [36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----."
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic                 csr_index;
   logic [UnitWidth-1:0] csr_wr_data;

   logic [UnitWidth-1:0] char_gap_len;
   logic [UnitWidth-1:0] word_gap_len;
   interval_type         expected_intervals [$];
   int                   fault_count;
   int                   send_idle_pct;
   int                   recv_idle_pct;

   mck_req_if req_if ();
   mck_rsp_if rsp_if ();

   morse_character_keyer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic void key_character(input logic [CharWidth-1:0] ch_in);
      logic [CharWidth-1:0] ch;
      string                pat;
      int                   i;
      ch = ch_in;
      if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'd32;
      if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h30 && ch <= 8'h39)) begin
         if (ch >= 8'h61) pat = morse_pat[ch - 8'h61];
         else pat = morse_pat[26 + (ch - 8'h30)];
         for (i = 0; i < pat.len(); i++) begin
            expected_intervals.push_back('{1'b1, (pat[i] == "-") ? DASH_UNITS : 4'd1, 1'b0});
            expected_intervals.push_back(SYM_OFF);
         end
      end else if (ch == 8'h20) begin
         expected_intervals.push_back('{1'b0, word_gap_len, 1'b0});
      end
      expected_intervals.push_back('{1'b0, char_gap_len, 1'b1});
   endfunction

   function automatic logic [CharWidth-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return CharWidth'($urandom_range(8'h61, 8'h7A));
      else if (r < 55) return CharWidth'($urandom_range(8'h41, 8'h5A));
      else if (r < 75) return CharWidth'($urandom_range(8'h30, 8'h39));
      else if (r < 85) return 8'h20;
      else return CharWidth'($urandom_range(0, 255));
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endtask

   // returns at the edge where the character transfer happens
   task automatic send_char(input logic [CharWidth-1:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.ascii_char <= ch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic set_gap(input logic idx, input logic [UnitWidth-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CHAR_GAP) char_gap_len = value;
      else word_gap_len = value;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_intervals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check each transfer, then pick ready for the next cycle
   initial begin
      interval_type got;
      interval_type want;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.led_on, rsp_if.duration_units, rsp_if.last};
            if (expected_intervals.size() == 0) begin
               report_fault($sformatf("unexpected interval led_on=%0b dur=%0d last=%0b",
                                      got.led_on, got.duration_units, got.last));
            end else begin
               want = expected_intervals.pop_front();
               if (got.led_on !== want.led_on || got.duration_units !== want.duration_units ||
                   got.last !== want.last)
                  report_fault($sformatf("expected led_on=%0b dur=%0d last=%0b, got %0b %0d %0b",
                                         want.led_on, want.duration_units, want.last,
                                         got.led_on, got.duration_units, got.last));
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      int row;
      int j;
      int phase;
      int n;
      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.ascii_char = '0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_CHAR_GAP;
      csr_wr_data       = '0;
      char_gap_len      = 4'd2;
      word_gap_len      = 4'd4;
      fault_count       = 0;
      send_idle_pct     = 22;
      recv_idle_pct     = 47;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < NUM_ROWS; row++) begin
         send_char(directed_rows[row].ch);
         if (directed_rows[row].n_typed > 0) begin
            for (j = 0; j < directed_rows[row].n_typed; j++)
               expected_intervals.push_back(directed_rows[row].typed[j]);
         end else begin
            key_character(directed_rows[row].ch);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         case (phase)
            0: begin set_gap(CSR_CHAR_GAP, 4'd0);  set_gap(CSR_WORD_GAP, 4'd0);  end
            1: begin set_gap(CSR_CHAR_GAP, 4'd15); set_gap(CSR_WORD_GAP, 4'd15); end
            2: begin set_gap(CSR_CHAR_GAP, 4'd0);  set_gap(CSR_WORD_GAP, 4'd15); end
            3: begin set_gap(CSR_CHAR_GAP, 4'd15); set_gap(CSR_WORD_GAP, 4'd0);  end
            default: begin
               set_gap(CSR_CHAR_GAP, UnitWidth'($urandom_range(0, 15)));
               set_gap(CSR_WORD_GAP, UnitWidth'($urandom_range(0, 15)));
            end
         endcase
         // receiver-heavy idling, then sender-heavy, then none
         if (phase < 2) begin
            send_idle_pct = 22;
            recv_idle_pct = 47;
         end else if (phase < 4) begin
            send_idle_pct = 47;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < CHARS_PER_PHASE; n++) begin
            logic [CharWidth-1:0] ch;
            ch = pick_char();
            send_char(ch);
            key_character(ch);
         end
      end

      drain();
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
